FILE: design/bdas_pkg.sv
// Shared types and constants for the button debouncer and axis smoother.
`default_nettype none
package bdas_pkg;

    localparam int unsigned SAMPLE_W  = 10;
    localparam int unsigned PERIOD_W  = 10;
    localparam int unsigned AXIS_W    = 8;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [PERIOD_W-1:0] CNT_MAX              = 10'd1023;
    localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RESET   = 10'd20;
    localparam logic [PERIOD_W-1:0] DEBOUNCE_PERIOD_RESET = 10'd40;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_PERIOD = 1'b1;

    // Click latch states
    typedef enum logic [1:0] {
        LATCH_RELEASED = 2'd0,
        LATCH_UNREAD   = 2'd1,
        LATCH_READ     = 2'd2
    } t_latch;

    // Input beat
    typedef struct packed {
        logic                menu_level;
        logic                joy_level;
        logic [SAMPLE_W-1:0] lr_sample;
        logic [SAMPLE_W-1:0] ud_sample;
        logic                read_menu_click;
        logic                read_joy_click;
    } t_in;

    // Result beat
    typedef struct packed {
        logic                     menu_pressed;
        logic                     joy_pressed;
        logic                     menu_click;
        logic                     joy_click;
        logic signed [AXIS_W-1:0] lr_value;
        logic signed [AXIS_W-1:0] ud_value;
    } t_out;

    // Item after the input register: axes already mapped
    typedef struct packed {
        logic                     menu_level;
        logic                     joy_level;
        logic signed [AXIS_W-1:0] lr_mapped;
        logic signed [AXIS_W-1:0] ud_mapped;
        logic                     read_menu_click;
        logic                     read_joy_click;
    } t_s1;

    // Request to one button unit
    typedef struct packed {
        logic step;
        logic debounce;
        logic level;
        logic read;
    } t_btn_req;

    // Response from one button unit
    typedef struct packed {
        logic pressed;
        logic click;
    } t_btn_res;

endpackage
`default_nettype wire

FILE: design/bdas_axis_map.sv
// Maps a 10-bit axis sample to -127..127 as (x*254)/1023 - 127.
`default_nettype none
module bdas_axis_map (
    input  wire logic [bdas_pkg::SAMPLE_W-1:0]      i_sample,
    output logic signed [bdas_pkg::AXIS_W-1:0]      o_mapped
);
    import bdas_pkg::*;

    logic [17:0] prod;
    logic [18:0] est_sum;
    logic [7:0]  q_est;
    logic [17:0] q_back;
    logic [17:0] rem;
    logic [7:0]  q;
    logic signed [8:0] centered;

    // Scale by 254 with shifts
    assign prod = {i_sample, 8'b0} - {7'b0, i_sample, 1'b0};

    // Estimate quotient by 1023 from 1/1024 + 1/1024^2; low by at most one
    assign est_sum = {1'b0, prod} + {11'b0, prod[17:10]};
    assign q_est   = est_sum[17:10];

    // Correct with one compare and subtract
    assign q_back = {q_est, 10'b0} - {10'b0, q_est};
    assign rem    = prod - q_back;
    assign q      = (rem >= 18'd1023) ? (q_est + 8'd1) : q_est;

    // Center around zero
    assign centered = $signed({1'b0, q}) - 9'sd127;
    assign o_mapped = centered[AXIS_W-1:0];

endmodule
`default_nettype wire

FILE: design/bdas_button.sv
// Debounce and click latch state for one active-low button.
`default_nettype none
module bdas_button (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bdas_pkg::t_btn_req i_req,
    output bdas_pkg::t_btn_res      o_res
);
    import bdas_pkg::*;

    logic   r_prev;
    logic   r_stable;
    t_latch r_latch;
    logic   n_prev;
    logic   n_stable;
    t_latch n_latch;
    logic   click;

    // Debounce first, then serve the read request
    always_comb begin
        n_prev   = r_prev;
        n_stable = r_stable;
        n_latch  = r_latch;
        click    = 1'b0;
        if (i_req.debounce) begin
            if (i_req.level == r_prev) begin
                n_stable = r_prev;
                if (r_prev) begin
                    n_latch = LATCH_RELEASED;
                end else if (r_latch == LATCH_RELEASED) begin
                    n_latch = LATCH_UNREAD;
                end
            end
            n_prev = i_req.level;
        end
        if (i_req.read && !n_stable && n_latch == LATCH_UNREAD) begin
            n_latch = LATCH_READ;
            click   = 1'b1;
        end
    end

    assign o_res.pressed = !n_stable;
    assign o_res.click   = click;

    // Advance state once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= 1'b1;
            r_stable <= 1'b1;
            r_latch  <= LATCH_RELEASED;
        end else if (i_req.step) begin
            r_prev   <= n_prev;
            r_stable <= n_stable;
            r_latch  <= n_latch;
        end
    end

endmodule
`default_nettype wire

FILE: design/button_debounce_and_axis_smoother_top.sv
// Top level: two-stage debouncer, click latch and axis smoother.
//
// Usage: each input beat is one millisecond tick carrying two raw button
// levels (0 = pressed), two 10-bit axis samples and two click read requests.
// Every tick gives exactly one result beat: debounced pressed flags, click
// flags and two smoothed axis values in -127..127.
// Path: an accepted beat sits in the input register, then moves into the
// result register, where it shows on the output; a stalled output holds it
// back in the input register.
// Throughput: one beat per cycle, sustained while the output is not stalled,
// set by the single state update in the second stage.
// Reset (synchronous, active low): both periods return to 20 and 40 ticks,
// counters and averages clear, buttons read as released, both stages empty.
// Stall: while the result register holds a stalled beat, the second stage
// freezes; the input register still takes one more beat if it is empty,
// then o_in_stall rises until the result is taken.
// Configuration: write i_cfg_data to register i_cfg_idx with i_cfg_we high;
// write only while no beats are in flight.
`default_nettype none
module button_debounce_and_axis_smoother_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire bdas_pkg::t_in                     i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output bdas_pkg::t_out                         o_out_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [bdas_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [bdas_pkg::PERIOD_W-1:0]     i_cfg_data
);
    import bdas_pkg::*;

    logic [PERIOD_W-1:0]      r_sample_period;
    logic [PERIOD_W-1:0]      r_debounce_period;
    logic [PERIOD_W-1:0]      r_since_sample;
    logic [PERIOD_W-1:0]      r_since_debounce;
    logic [PERIOD_W-1:0]      n_since_sample;
    logic [PERIOD_W-1:0]      n_since_debounce;
    logic [PERIOD_W-1:0]      inc_sample;
    logic [PERIOD_W-1:0]      inc_debounce;
    logic signed [AXIS_W-1:0] r_lr_avg;
    logic signed [AXIS_W-1:0] r_ud_avg;
    logic signed [AXIS_W-1:0] n_lr_avg;
    logic signed [AXIS_W-1:0] n_ud_avg;
    logic signed [AXIS_W-1:0] lr_mapped;
    logic signed [AXIS_W-1:0] ud_mapped;
    logic signed [AXIS_W:0]   lr_sum;
    logic signed [AXIS_W:0]   ud_sum;
    logic signed [AXIS_W:0]   lr_half;
    logic signed [AXIS_W:0]   ud_half;
    logic                     r_s1_valid;
    t_s1                      r_s1;
    logic                     r_out_valid;
    t_out                     r_out;
    logic                     advance;
    logic                     s1_load;
    logic                     step;
    logic                     sample_tick;
    logic                     debounce_tick;
    t_btn_req                 menu_req;
    t_btn_req                 joy_req;
    t_btn_res                 menu_res;
    t_btn_res                 joy_res;

    // Handshake: result register moves unless held, input register refills
    assign advance    = !(r_out_valid && i_out_stall);
    assign s1_load    = advance || !r_s1_valid;
    assign o_in_stall = !s1_load;
    assign step       = advance && r_s1_valid;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_period   <= SAMPLE_PERIOD_RESET;
            r_debounce_period <= DEBOUNCE_PERIOD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SAMPLE_PERIOD:   r_sample_period   <= i_cfg_data;
                CFG_DEBOUNCE_PERIOD: r_debounce_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage one: map both axes
    bdas_axis_map u_lr_map (
        .i_sample (i_in_data.lr_sample),
        .o_mapped (lr_mapped)
    );

    bdas_axis_map u_ud_map (
        .i_sample (i_in_data.ud_sample),
        .o_mapped (ud_mapped)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && i_in_valid) begin
            r_s1.menu_level      <= i_in_data.menu_level;
            r_s1.joy_level       <= i_in_data.joy_level;
            r_s1.lr_mapped       <= lr_mapped;
            r_s1.ud_mapped       <= ud_mapped;
            r_s1.read_menu_click <= i_in_data.read_menu_click;
            r_s1.read_joy_click  <= i_in_data.read_joy_click;
        end
    end

    // Stage two: saturating tick counters and period checks
    always_comb begin
        inc_sample    = (r_since_sample < CNT_MAX) ? r_since_sample + 1'b1 : r_since_sample;
        inc_debounce  = (r_since_debounce < CNT_MAX) ? r_since_debounce + 1'b1
                                                     : r_since_debounce;
        sample_tick   = inc_sample >= r_sample_period;
        debounce_tick = sample_tick && (inc_debounce >= r_debounce_period);
        n_since_sample   = sample_tick ? '0 : inc_sample;
        n_since_debounce = debounce_tick ? '0 : inc_debounce;
    end

    // Average with stored value, halve toward zero
    always_comb begin
        lr_sum  = $signed({r_lr_avg[AXIS_W-1], r_lr_avg})
                + $signed({r_s1.lr_mapped[AXIS_W-1], r_s1.lr_mapped});
        ud_sum  = $signed({r_ud_avg[AXIS_W-1], r_ud_avg})
                + $signed({r_s1.ud_mapped[AXIS_W-1], r_s1.ud_mapped});
        lr_half = (lr_sum + $signed({{AXIS_W{1'b0}}, lr_sum[AXIS_W]})) >>> 1;
        ud_half = (ud_sum + $signed({{AXIS_W{1'b0}}, ud_sum[AXIS_W]})) >>> 1;
        n_lr_avg = sample_tick ? lr_half[AXIS_W-1:0] : r_lr_avg;
        n_ud_avg = sample_tick ? ud_half[AXIS_W-1:0] : r_ud_avg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since_sample   <= '0;
            r_since_debounce <= '0;
            r_lr_avg         <= '0;
            r_ud_avg         <= '0;
        end else if (step) begin
            r_since_sample   <= n_since_sample;
            r_since_debounce <= n_since_debounce;
            r_lr_avg         <= n_lr_avg;
            r_ud_avg         <= n_ud_avg;
        end
    end

    // Buttons
    assign menu_req.step     = step;
    assign menu_req.debounce = step && debounce_tick;
    assign menu_req.level    = r_s1.menu_level;
    assign menu_req.read     = r_s1.read_menu_click;

    assign joy_req.step      = step;
    assign joy_req.debounce  = step && debounce_tick;
    assign joy_req.level     = r_s1.joy_level;
    assign joy_req.read      = r_s1.read_joy_click;

    bdas_button u_menu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (menu_req),
        .o_res   (menu_res)
    );

    bdas_button u_joy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (joy_req),
        .o_res   (joy_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out.menu_pressed <= menu_res.pressed;
            r_out.joy_pressed  <= joy_res.pressed;
            r_out.menu_click   <= menu_res.click;
            r_out.joy_click    <= joy_res.click;
            r_out.lr_value     <= n_lr_avg;
            r_out.ud_value     <= n_ud_avg;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

FILE: design/bdas_checker.sv
// Port-level checks for the top level, bound to it.
`default_nettype none
module bdas_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              o_in_stall,
    input wire bdas_pkg::t_in                     i_in_data,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_stall,
    input wire bdas_pkg::t_out                    o_out_data,
    input wire logic                              i_cfg_we,
    input wire logic [bdas_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input wire logic [bdas_pkg::PERIOD_W-1:0]     i_cfg_data
);
    import bdas_pkg::*;

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Held result beat stays valid
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // A click is only reported for a debounced press
    a_click_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.menu_click || o_out_data.menu_pressed)
                     && (!o_out_data.joy_click || o_out_data.joy_pressed))
        else $error("click without pressed button");

    // Axis averages stay inside -127..127
    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.lr_value != 8'sh80 && o_out_data.ud_value != 8'sh80)
        else $error("axis value out of range");

    // The input stalls only while a result beat is held in a stalled result register
    a_in_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output free");

endmodule

bind button_debounce_and_axis_smoother_top bdas_checker u_bdas_checker (.*);
`default_nettype wire

FILE: tb/tb_button_debounce_and_axis_smoother_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the button debouncer, click latch and axis smoother.
module tb_button_debounce_and_axis_smoother_top;
    import bdas_pkg::*;

    localparam int CLK_HIGH_NS   = 6;
    localparam int CLK_LOW_NS    = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_CAP    = 200;
    localparam int KEY_MENU      = 0;
    localparam int KEY_JOY       = 1;

    // DUT connections
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in                   in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out                  out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_SAMPLE_PERIOD;
    logic [PERIOD_W-1:0]   cfg_data  = '0;

    // Mirror of the block state
    logic [PERIOD_W-1:0]      sample_period        = SAMPLE_PERIOD_RESET;
    logic [PERIOD_W-1:0]      debounce_period      = DEBOUNCE_PERIOD_RESET;
    logic [PERIOD_W-1:0]      ticks_since_sample   = '0;
    logic [PERIOD_W-1:0]      ticks_since_debounce = '0;
    logic [1:0]               key_prev_raw         = 2'b11;
    logic [1:0]               key_stable           = 2'b11;
    t_latch                   key_latch [2];
    logic signed [AXIS_W-1:0] lr_smooth            = '0;
    logic signed [AXIS_W-1:0] ud_smooth            = '0;

    // Tick queues and bookkeeping
    t_in  pending_ticks [$];
    t_out expected_results [$];
    int   ticks_queued  = 0;
    int   ticks_checked = 0;
    int   mismatches    = 0;
    logic calm          = 1'b0;

    button_debounce_and_axis_smoother_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // Free-running clock
    always begin
        #CLK_HIGH_NS clk = 1'b1;
        #CLK_LOW_NS  clk = 1'b0;
    end

    // Map a raw sample to -127..127 and average it into the stored value
    function automatic logic signed [AXIS_W-1:0] smooth_axis(
        logic signed [AXIS_W-1:0] avg, logic [SAMPLE_W-1:0] raw);
        int mapped;
        mapped = (int'(raw) * 254) / 1023 - 127;
        return AXIS_W'((int'(avg) + mapped) / 2);
    endfunction

    // Accept a level only when it repeats the previous raw sample
    function automatic void debounce_key(int k, logic level);
        if (level == key_prev_raw[k]) begin
            key_stable[k] = key_prev_raw[k];
            if (key_prev_raw[k])
                key_latch[k] = LATCH_RELEASED;
            else if (key_latch[k] == LATCH_RELEASED)
                key_latch[k] = LATCH_UNREAD;
        end
        key_prev_raw[k] = level;
    endfunction

    // Consume an unread press when the consumer asks for it
    function automatic logic take_click(int k, logic req);
        if (req && !key_stable[k] && key_latch[k] == LATCH_UNREAD) begin
            key_latch[k] = LATCH_READ;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the mirror by one tick and return the beat it should produce
    function automatic t_out advance_tick(t_in tick);
        t_out res;
        if (ticks_since_sample != CNT_MAX)
            ticks_since_sample++;
        if (ticks_since_debounce != CNT_MAX)
            ticks_since_debounce++;
        if (ticks_since_sample >= sample_period) begin
            if (ticks_since_debounce >= debounce_period) begin
                debounce_key(KEY_MENU, tick.menu_level);
                debounce_key(KEY_JOY, tick.joy_level);
                ticks_since_debounce = '0;
            end
            lr_smooth = smooth_axis(lr_smooth, tick.lr_sample);
            ud_smooth = smooth_axis(ud_smooth, tick.ud_sample);
            ticks_since_sample = '0;
        end
        res.menu_click   = take_click(KEY_MENU, tick.read_menu_click);
        res.joy_click    = take_click(KEY_JOY, tick.read_joy_click);
        res.menu_pressed = !key_stable[KEY_MENU];
        res.joy_pressed  = !key_stable[KEY_JOY];
        res.lr_value     = lr_smooth;
        res.ud_value     = ud_smooth;
        return res;
    endfunction

    function automatic void compare_field(string field, int want, int got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, field, want, got);
        end
    endfunction

    // Driver: present queued ticks, hold while stalled, insert idle bursts
    int   send_gap       = 0;
    int   send_mood_left = 0;
    logic send_moody     = 1'b0;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                expected_results.push_back(advance_tick(in_data));
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (!calm && send_moody && $urandom_range(0, 4) == 0) begin
                    send_gap = $urandom_range(0, 8);
                    in_valid <= 1'b0;
                end else if (pending_ticks.size() != 0) begin
                    in_data  <= pending_ticks.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            if (send_mood_left == 0) begin
                send_mood_left = $urandom_range(20, 80);
                send_moody     = ($urandom_range(0, 2) != 0);
            end else begin
                send_mood_left--;
            end
        end
    end

    // Monitor: check each accepted result beat, stall in random bursts
    int   stall_left      = 0;
    int   recv_mood_left  = 0;
    logic recv_moody      = 1'b0;

    always @(posedge clk) begin : monitor
        t_out want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat: expected none, actual %p",
                             $time, out_data);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("menu_pressed", want.menu_pressed, out_data.menu_pressed);
                    compare_field("joy_pressed", want.joy_pressed, out_data.joy_pressed);
                    compare_field("menu_click", want.menu_click, out_data.menu_click);
                    compare_field("joy_click", want.joy_click, out_data.joy_click);
                    compare_field("lr_value", int'(want.lr_value), int'(out_data.lr_value));
                    compare_field("ud_value", int'(want.ud_value), int'(out_data.ud_value));
                    ticks_checked++;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (!calm && recv_moody && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 8);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
            if (recv_mood_left == 0) begin
                recv_mood_left = $urandom_range(20, 80);
                recv_moody     = ($urandom_range(0, 2) != 0);
            end else begin
                recv_mood_left--;
            end
        end
    end

    task automatic push_tick(logic menu, logic joy, logic [SAMPLE_W-1:0] lr,
                             logic [SAMPLE_W-1:0] ud, logic rd_menu, logic rd_joy);
        t_in tick;
        tick.menu_level      = menu;
        tick.joy_level       = joy;
        tick.lr_sample       = lr;
        tick.ud_sample       = ud;
        tick.read_menu_click = rd_menu;
        tick.read_joy_click  = rd_joy;
        pending_ticks.push_back(tick);
        ticks_queued++;
    endtask

    function automatic int next_hold(int hold_max);
        return ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(1, hold_max);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // Random press and release runs with bounces, noisy pins and random reads
    task automatic queue_random_ticks(int count, int hold_max);
        int   menu_hold;
        int   joy_hold;
        logic menu_lvl;
        logic joy_lvl;
        logic menu_pin;
        logic joy_pin;
        menu_hold = 0;
        joy_hold  = 0;
        menu_lvl  = 1'b1;
        joy_lvl   = 1'b1;
        repeat (count) begin
            if (menu_hold == 0) begin
                menu_lvl  = !menu_lvl;
                menu_hold = next_hold(hold_max);
            end
            if (joy_hold == 0) begin
                joy_lvl  = !joy_lvl;
                joy_hold = next_hold(hold_max);
            end
            menu_hold--;
            joy_hold--;
            menu_pin = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : menu_lvl;
            joy_pin  = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : joy_lvl;
            push_tick(menu_pin, joy_pin, pick_sample(), pick_sample(),
                      $urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0);
        end
    endtask

    // Wait until every queued tick has been checked, then let the pipe empty
    task automatic settle();
        while (ticks_checked != ticks_queued)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_periods(logic [PERIOD_W-1:0] samp, logic [PERIOD_W-1:0] deb);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SAMPLE_PERIOD;
        cfg_data <= samp;
        @(posedge clk);
        cfg_idx  <= CFG_DEBOUNCE_PERIOD;
        cfg_data <= deb;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sample_period   = samp;
        debounce_period = deb;
    endtask

    // Cycle watchdog
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Main sequence
    initial begin : stimulus
        key_latch[KEY_MENU] = LATCH_RELEASED;
        key_latch[KEY_JOY]  = LATCH_RELEASED;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Zero periods: sample and debounce on every tick
        program_periods('0, '0);
        push_tick(1, 1,    0, 1023, 0, 0);
        push_tick(1, 1, 1023,    0, 0, 0);
        push_tick(1, 1, 1023, 1023, 0, 0);
        push_tick(1, 1, 1023, 1023, 0, 0);
        push_tick(1, 1,    0,    0, 0, 0);
        // read with nothing pressed
        push_tick(1, 1,  511,  512, 1, 1);
        // menu press: first low sample is not yet trusted, then click once
        push_tick(0, 1,  512,  511, 1, 0);
        push_tick(0, 1,  300,  700, 1, 0);
        push_tick(0, 1,  700,  300, 1, 0);
        // menu bounce while joy goes down
        push_tick(1, 0,    1, 1022, 0, 1);
        push_tick(0, 0, 1022,    1, 0, 1);
        push_tick(0, 0,  100,  900, 1, 1);
        // release both
        push_tick(1, 1,  900,  100, 1, 1);
        push_tick(1, 1,  512,  512, 1, 1);
        // press both together, read both on the same tick
        push_tick(0, 0,    0,    0, 0, 0);
        push_tick(0, 0, 1023, 1023, 0, 0);
        push_tick(0, 0, 1023,    0, 1, 1);
        push_tick(1, 1,    0, 1023, 0, 0);
        push_tick(1, 1,  255,  768, 1, 1);
        queue_random_ticks(150, 6);
        settle();

        program_periods(10'd2, 10'd5);
        queue_random_ticks(150, 24);
        settle();

        program_periods(10'd5, 10'd2);
        queue_random_ticks(120, 24);
        settle();

        program_periods(SAMPLE_PERIOD_RESET, DEBOUNCE_PERIOD_RESET);
        queue_random_ticks(100, 170);
        settle();

        // Longest periods: the check passes just as the counters reach their saturation limit
        program_periods(CNT_MAX, CNT_MAX);
        queue_random_ticks(1030, 2500);
        settle();

        // Closing stretch at full rate
        calm = 1'b1;
        program_periods(10'd1, '0);
        queue_random_ticks(100, 8);
        settle();

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
